// File: design/sdsd_pkg.sv
// shared command types and op-byte constants for the symbol delta stream decoder
`default_nettype none

package sdsd_pkg;

	// op byte bit positions
	localparam int unsigned OP_FILE_BIT   = 7;
	localparam int unsigned OP_FUNC_BIT   = 6;
	localparam int unsigned OP_LINE_BIT   = 5;
	localparam int unsigned OP_FSTART_BIT = 4;
	localparam int unsigned OP_INLINE_BIT = 3;

	// address step code that means an extra varint follows
	localparam logic [2:0] STEP_EXTRA = 3'h7;

	// command kinds passed from parser to executor
	typedef enum logic [1:0] {
		CMD_CHUNK,
		CMD_LFA,
		CMD_REC
	} cmd_kind_t;

	// one parsed command word
	typedef struct packed {
		cmd_kind_t   kind;
		logic [31:0] addr;
		logic [31:0] lfa;
		logic [7:0]  op;
		logic [31:0] d_file;
		logic [31:0] d_func;
		logic [31:0] d_line;
		logic [31:0] step;
		logic        cut;
	} cmd_t;

endpackage

`default_nettype wire

// File: design/sdsd_front.sv
// byte parser: varint assembly, op decode, command generation
`default_nettype none

module sdsd_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              byte_valid,
	output logic                   byte_stall,
	input  wire logic [7:0]        stream_byte,
	input  wire logic              first_of_chunk,
	input  wire logic              last_of_chunk,
	input  wire logic [31:0]       chunk_start_addr,
	output logic                   push,
	output sdsd_pkg::cmd_t         push_cmd,
	input  wire logic              queue_full
);

	typedef enum logic [2:0] {
		PH_HDR,
		PH_OP,
		PH_FILE,
		PH_FUNC,
		PH_LINE,
		PH_ADDR,
		PH_IDLE
	} phase_t;

	localparam logic [5:0] SHIFT_CAP = 6'd35;
	localparam logic [5:0] SHIFT_TOP = 6'd32;

	// first field phase after 'from' that the op still needs, else PH_OP
	function automatic phase_t next_phase(input logic [7:0] op, input phase_t from);
		phase_t nxt;
		nxt = PH_OP;
		if (from < PH_FILE && op[sdsd_pkg::OP_FILE_BIT])
			nxt = PH_FILE;
		else if (from < PH_FUNC && op[sdsd_pkg::OP_FUNC_BIT])
			nxt = PH_FUNC;
		else if (from < PH_LINE && op[sdsd_pkg::OP_LINE_BIT])
			nxt = PH_LINE;
		else if (from < PH_ADDR && op[2:0] == sdsd_pkg::STEP_EXTRA)
			nxt = PH_ADDR;
		return nxt;
	endfunction

	function automatic logic [31:0] zigzag(input logic [31:0] v);
		return (v >> 1) ^ (32'd0 - {31'd0, v[0]});
	endfunction

	phase_t      phase_q;
	logic [31:0] acc_q;
	logic [5:0]  shift_q;
	logic [7:0]  held_q;
	logic [31:0] base_q;
	logic [31:0] pend_q [4];

	phase_t      ph_e;
	phase_t      ph_n;
	logic [31:0] acc_e;
	logic [31:0] acc_new;
	logic [31:0] acc_n;
	logic [5:0]  shift_e;
	logic [5:0]  shift_sum;
	logic [5:0]  shift_new;
	logic [5:0]  shift_n;
	logic [7:0]  held_e;
	logic [7:0]  held_n;
	logic [31:0] base_e;
	logic [31:0] pend_e [4];
	logic [31:0] pend_n [4];
	logic [31:0] extra_sum;
	logic        done;
	logic        accept;
	logic        push_c;
	logic        rec_c;
	logic        cut_c;
	logic [31:0] lfa_c;

	assign byte_stall = queue_full;
	assign accept     = byte_valid & ~queue_full;
	assign push       = accept & push_c;

	// effective state: chunk start clears context before the byte is used
	always_comb begin
		ph_e    = first_of_chunk ? PH_HDR : phase_q;
		acc_e   = first_of_chunk ? 32'd0 : acc_q;
		shift_e = first_of_chunk ? 6'd0 : shift_q;
		held_e  = first_of_chunk ? 8'd0 : held_q;
		base_e  = first_of_chunk ? chunk_start_addr : base_q;
		for (int i = 0; i < 4; i++)
			pend_e[i] = first_of_chunk ? 32'd0 : pend_q[i];
	end

	// varint byte merge
	always_comb begin
		done      = ~stream_byte[7];
		acc_new   = acc_e;
		if (shift_e < SHIFT_TOP)
			acc_new = acc_e | ({25'd0, stream_byte[6:0]} << shift_e[4:0]);
		shift_sum = shift_e + 6'd7;
		shift_new = (shift_sum > SHIFT_CAP) ? SHIFT_CAP : shift_sum;
	end

	// phase step and command build
	always_comb begin
		ph_n    = ph_e;
		acc_n   = acc_e;
		shift_n = shift_e;
		held_n  = held_e;
		for (int i = 0; i < 4; i++)
			pend_n[i] = pend_e[i];
		push_c  = first_of_chunk;
		rec_c   = 1'b0;
		cut_c   = 1'b0;
		lfa_c   = 32'd0;

		unique case (ph_e)
			PH_HDR: begin
				acc_n   = acc_new;
				shift_n = shift_new;
				if (done) begin
					lfa_c   = (acc_new != 32'd0) ? (base_e - acc_new) : 32'd0;
					push_c  = 1'b1;
					acc_n   = 32'd0;
					shift_n = 6'd0;
					ph_n    = PH_OP;
				end
			end
			PH_OP: begin
				held_n  = stream_byte;
				for (int i = 0; i < 4; i++)
					pend_n[i] = 32'd0;
				acc_n   = 32'd0;
				shift_n = 6'd0;
				ph_n    = next_phase(stream_byte, PH_OP);
				if (ph_n == PH_OP)
					rec_c = 1'b1;
			end
			PH_FILE, PH_FUNC, PH_LINE, PH_ADDR: begin
				acc_n   = acc_new;
				shift_n = shift_new;
				if (done) begin
					unique case (ph_e)
						PH_FILE: pend_n[0] = zigzag(acc_new);
						PH_FUNC: pend_n[1] = zigzag(acc_new);
						PH_LINE: pend_n[2] = zigzag(acc_new);
						default: pend_n[3] = acc_new;
					endcase
					acc_n   = 32'd0;
					shift_n = 6'd0;
					ph_n    = next_phase(held_e, ph_e);
					if (ph_n == PH_OP)
						rec_c = 1'b1;
				end
			end
			default: begin
				ph_n = PH_IDLE;
			end
		endcase

		// end of chunk: flush an open record with what has arrived
		if (last_of_chunk) begin
			if (ph_n == PH_FILE || ph_n == PH_FUNC || ph_n == PH_LINE || ph_n == PH_ADDR) begin
				unique case (ph_n)
					PH_FILE: pend_n[0] = zigzag(acc_n);
					PH_FUNC: pend_n[1] = zigzag(acc_n);
					PH_LINE: pend_n[2] = zigzag(acc_n);
					default: pend_n[3] = acc_n;
				endcase
				rec_c = 1'b1;
				cut_c = 1'b1;
			end
			ph_n    = PH_IDLE;
			acc_n   = 32'd0;
			shift_n = 6'd0;
		end

		if (rec_c)
			push_c = 1'b1;

		extra_sum       = pend_n[3] + 32'd7;
		push_cmd.kind   = rec_c ? sdsd_pkg::CMD_REC :
		                  (first_of_chunk ? sdsd_pkg::CMD_CHUNK : sdsd_pkg::CMD_LFA);
		push_cmd.addr   = base_e;
		push_cmd.lfa    = lfa_c;
		push_cmd.op     = held_n;
		push_cmd.d_file = pend_n[0];
		push_cmd.d_func = pend_n[1];
		push_cmd.d_line = pend_n[2];
		push_cmd.step   = (held_n[2:0] == sdsd_pkg::STEP_EXTRA) ?
		                  {extra_sum[29:0], 2'b00} : {27'd0, held_n[2:0], 2'b00};
		push_cmd.cut    = cut_c;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			acc_q   <= 32'd0;
			shift_q <= 6'd0;
			held_q  <= 8'd0;
			base_q  <= 32'd0;
			for (int i = 0; i < 4; i++)
				pend_q[i] <= 32'd0;
		end else if (accept) begin
			phase_q <= ph_n;
			acc_q   <= acc_n;
			shift_q <= shift_n;
			held_q  <= held_n;
			base_q  <= base_e;
			for (int i = 0; i < 4; i++)
				pend_q[i] <= pend_n[i];
		end
	end

endmodule

`default_nettype wire

// File: design/sdsd_queue.sv
// small command queue between parser and executor
`default_nettype none

module sdsd_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  sdsd_pkg::cmd_t      push_cmd,
	output logic                full,
	input  wire logic           pop,
	output sdsd_pkg::cmd_t      pop_cmd,
	output logic                empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	sdsd_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: design/sdsd_back.sv
// executor: context accumulators, address tracking and record output register
`default_nettype none

module sdsd_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  sdsd_pkg::cmd_t          pop_cmd,
	input  wire logic               empty,
	output logic                    pop,
	output logic                    record_valid,
	input  wire logic               record_stall,
	output logic [31:0]             symbol_addr,
	output logic signed [31:0]      file_number,
	output logic signed [31:0]      function_number,
	output logic signed [31:0]      line_number,
	output logic [31:0]             function_offset,
	output logic                    is_function_start,
	output logic                    is_inline_record,
	output logic [31:0]             record_count,
	output logic                    cut_short
);

	logic [31:0] ctx_file_q [2];
	logic [31:0] ctx_func_q [2];
	logic [31:0] ctx_line_q [2];
	logic [31:0] cur_q;
	logic [31:0] lfa_q;
	logic [31:0] seen_q;
	logic        out_valid_q;

	logic [31:0] sym_q;
	logic [31:0] file_q;
	logic [31:0] func_q;
	logic [31:0] line_q;
	logic [31:0] foff_q;
	logic        fstart_q;
	logic        inline_q;
	logic [31:0] count_q;
	logic        cut_q;

	logic        is_rec;
	logic        sid;
	logic [31:0] file_n;
	logic [31:0] func_n;
	logic [31:0] line_n;
	logic [31:0] sym_n;
	logic [31:0] foff_n;
	logic        fstart;

	assign is_rec = (pop_cmd.kind == sdsd_pkg::CMD_REC);
	assign pop    = ~empty & (~is_rec | ~out_valid_q | ~record_stall);

	// record arithmetic
	always_comb begin
		sid    = pop_cmd.op[sdsd_pkg::OP_INLINE_BIT];
		fstart = pop_cmd.op[sdsd_pkg::OP_FSTART_BIT];
		file_n = ctx_file_q[sid] + pop_cmd.d_file;
		func_n = ctx_func_q[sid] + pop_cmd.d_func;
		line_n = ctx_line_q[sid] + pop_cmd.d_line;
		sym_n  = cur_q + pop_cmd.step;
		// a function start makes the offset zero
		foff_n = (fstart || lfa_q == 32'd0) ? 32'd0 : (sym_n - lfa_q);
	end

	// context and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				ctx_file_q[i] <= 32'd0;
				ctx_func_q[i] <= 32'd0;
				ctx_line_q[i] <= 32'd0;
			end
			cur_q       <= 32'd0;
			lfa_q       <= 32'd0;
			seen_q      <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			// output word held until taken
			if (pop && is_rec)
				out_valid_q <= 1'b1;
			else if (!record_stall)
				out_valid_q <= 1'b0;
			if (pop) begin
				unique case (pop_cmd.kind)
					sdsd_pkg::CMD_CHUNK: begin
						for (int i = 0; i < 2; i++) begin
							ctx_file_q[i] <= 32'd0;
							ctx_func_q[i] <= 32'd0;
							ctx_line_q[i] <= 32'd0;
						end
						cur_q <= pop_cmd.addr;
						lfa_q <= pop_cmd.lfa;
					end
					sdsd_pkg::CMD_LFA: begin
						lfa_q <= pop_cmd.lfa;
					end
					sdsd_pkg::CMD_REC: begin
						ctx_file_q[sid] <= file_n;
						ctx_func_q[sid] <= func_n;
						ctx_line_q[sid] <= line_n;
						cur_q           <= sym_n;
						if (fstart)
							lfa_q <= sym_n;
						seen_q <= seen_q + 32'd1;
					end
					default: begin
						lfa_q <= lfa_q;
					end
				endcase
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (pop && is_rec) begin
			sym_q    <= sym_n;
			file_q   <= file_n;
			func_q   <= func_n;
			line_q   <= line_n;
			foff_q   <= foff_n;
			fstart_q <= fstart;
			inline_q <= sid;
			count_q  <= seen_q;
			cut_q    <= pop_cmd.cut;
		end
	end

	assign record_valid      = out_valid_q;
	assign symbol_addr       = sym_q;
	assign file_number       = $signed(file_q);
	assign function_number   = $signed(func_q);
	assign line_number       = $signed(line_q);
	assign function_offset   = foff_q;
	assign is_function_start = fstart_q;
	assign is_inline_record  = inline_q;
	assign record_count      = count_q;
	assign cut_short         = cut_q;

endmodule

`default_nettype wire

// File: design/symbol_delta_stream_decoder.sv
// top level of the symbol delta stream decoder
`default_nettype none

// Decodes a symbol chunk byte stream into one record word per op. A byte is
// taken every cycle while byte_stall is low; byte_stall rises only when the
// QUEUE_DEPTH-entry command queue between the byte parser and the executor is
// full, which happens only while the record output is held by record_stall.
// Each byte that completes a record (or ends a chunk inside one) yields a word
// once its command has passed the queue storage and the executor's output
// register. Sustained rate is one byte per cycle while byte_stall is low.
// A chunk starts on a byte with first_of_chunk set, which resets all
// context; bytes after a last_of_chunk byte are ignored until the next one.

module symbol_delta_stream_decoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          byte_valid,
	output logic               byte_stall,
	input  wire logic [7:0]    stream_byte,
	input  wire logic          first_of_chunk,
	input  wire logic          last_of_chunk,
	input  wire logic [31:0]   chunk_start_addr,
	output logic               record_valid,
	input  wire logic          record_stall,
	output logic [31:0]        symbol_addr,
	output logic signed [31:0] file_number,
	output logic signed [31:0] function_number,
	output logic signed [31:0] line_number,
	output logic [31:0]        function_offset,
	output logic               is_function_start,
	output logic               is_inline_record,
	output logic [31:0]        record_count,
	output logic               cut_short
);

	logic           push;
	logic           pop;
	logic           full;
	logic           empty;
	sdsd_pkg::cmd_t push_cmd;
	sdsd_pkg::cmd_t pop_cmd;

	// byte parser
	sdsd_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.byte_valid       (byte_valid),
		.byte_stall       (byte_stall),
		.stream_byte      (stream_byte),
		.first_of_chunk   (first_of_chunk),
		.last_of_chunk    (last_of_chunk),
		.chunk_start_addr (chunk_start_addr),
		.push             (push),
		.push_cmd         (push_cmd),
		.queue_full       (full)
	);

	// command queue
	sdsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (empty)
	);

	// executor and output register
	sdsd_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.pop_cmd           (pop_cmd),
		.empty             (empty),
		.pop               (pop),
		.record_valid      (record_valid),
		.record_stall      (record_stall),
		.symbol_addr       (symbol_addr),
		.file_number       (file_number),
		.function_number   (function_number),
		.line_number       (line_number),
		.function_offset   (function_offset),
		.is_function_start (is_function_start),
		.is_inline_record  (is_inline_record),
		.record_count      (record_count),
		.cut_short         (cut_short)
	);

endmodule

`default_nettype wire

// File: tb/tb_symbol_delta_stream_decoder.sv
// self-checking testbench for the symbol delta stream decoder
module tb_symbol_delta_stream_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_WORDS  = 170;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 10;

	// parser position, ordered as the fields follow an op byte
	typedef enum logic [2:0] {
		PARSE_HEADER,
		PARSE_OP,
		PARSE_FILE,
		PARSE_FUNC,
		PARSE_LINE,
		PARSE_STEP,
		PARSE_DONE
	} parse_phase_t;

	typedef struct packed {
		logic [31:0]        rec_addr;
		logic signed [31:0] file_num;
		logic signed [31:0] func_num;
		logic signed [31:0] line_num;
		logic [31:0]        fn_offset;
		logic               fn_start;
		logic               inline_rec;
		logic [31:0]        rec_index;
		logic               cut;
	} symbol_record_t;

	typedef struct packed {
		logic [7:0]     b;
		logic           first;
		logic           last;
		logic [31:0]    start;
		logic           has_typed;
		symbol_record_t typed;
	} stream_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               byte_valid = 1'b0;
	logic               byte_stall;
	logic [7:0]         stream_byte = '0;
	logic               first_of_chunk = 1'b0;
	logic               last_of_chunk = 1'b0;
	logic [31:0]        chunk_start_addr = '0;
	logic               record_valid;
	logic               record_stall = 1'b0;
	logic [31:0]        symbol_addr;
	logic signed [31:0] file_number;
	logic signed [31:0] function_number;
	logic signed [31:0] line_number;
	logic [31:0]        function_offset;
	logic               is_function_start;
	logic               is_inline_record;
	logic [31:0]        record_count;
	logic               cut_short;

	// typed expectation travelling with the word on the bus
	logic               word_has_typed = 1'b0;
	symbol_record_t     word_typed = '0;

	symbol_record_t     expected_records[$];
	stream_word_t       word_plan[$];
	logic [7:0]         chunk_bytes[$];
	int                 error_count = 0;
	int                 cycle_count = 0;
	int                 send_idle_pct = 0;
	int                 recv_stall_pct = 0;
	int                 hold_left = 0;
	bit                 hold_request = 1'b0;

	// decoder shadow state
	parse_phase_t       parse_at = PARSE_HEADER;
	logic [31:0]        group_acc = '0;
	int                 group_shift = 0;
	logic [7:0]         held_op = '0;
	logic [31:0]        file_delta = '0;
	logic [31:0]        func_delta = '0;
	logic [31:0]        line_delta = '0;
	logic [31:0]        extra_words = '0;
	logic [31:0]        addr_now = '0;
	logic [31:0]        fn_addr = '0;
	logic [31:0]        ctx_file[2] = '{default: '0};
	logic [31:0]        ctx_func[2] = '{default: '0};
	logic [31:0]        ctx_line[2] = '{default: '0};
	logic [31:0]        records_out = '0;

	// directed words: reset behavior, extremes, split varints, chunk ends
	stream_word_t directed_rows[25] = '{
		'{8'h00, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
		'{8'h01, 1'b0, 1'b0, 32'h0000_0000, 1'b1,
			'{32'h4, 32'sh0, 32'sh0, 32'sh0, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0}},
		'{8'h10, 1'b0, 1'b0, 32'h0000_0000, 1'b1,
			'{32'h4, 32'sh0, 32'sh0, 32'sh0, 32'h0, 1'b1, 1'b0, 32'h1, 1'b0}},
		'{8'h81, 1'b1, 1'b0, 32'h0000_1000, 1'b0, '0},
		'{8'h01, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
		'{8'hE8, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
		'{8'h01, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
		'{8'h7F, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
		'{8'h02, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
		'{8'h1F, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
		'{8'h7F, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
		'{8'h27, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
		'{8'h03, 1'b0, 1'b0, 32'h0000_0000, 1'b0, '0},
		'{8'h85, 1'b0, 1'b1, 32'h0000_0000, 1'b0, '0},
		'{8'h55, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, '0},
		'{8'h00, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, '0},
		'{8'hFF, 1'b1, 1'b1, 32'h0000_0000, 1'b0, '0},
		'{8'h00, 1'b1, 1'b0, 32'h8000_0000, 1'b0, '0},
		'{8'h80, 1'b0, 1'b1, 32'h0000_0000, 1'b1,
			'{32'h8000_0000, 32'sh0, 32'sh0, 32'sh0, 32'h0, 1'b0, 1'b0, 32'h5, 1'b1}}
	};

	symbol_delta_stream_decoder u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.byte_valid        (byte_valid),
		.byte_stall        (byte_stall),
		.stream_byte       (stream_byte),
		.first_of_chunk    (first_of_chunk),
		.last_of_chunk     (last_of_chunk),
		.chunk_start_addr  (chunk_start_addr),
		.record_valid      (record_valid),
		.record_stall      (record_stall),
		.symbol_addr       (symbol_addr),
		.file_number       (file_number),
		.function_number   (function_number),
		.line_number       (line_number),
		.function_offset   (function_offset),
		.is_function_start (is_function_start),
		.is_inline_record  (is_inline_record),
		.record_count      (record_count),
		.cut_short         (cut_short)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// one 7-bit group into the varint; true when the varint is complete
	function automatic bit take_group(input logic [7:0] b);
		if (group_shift < 32)
			group_acc = group_acc | (32'(b[6:0]) << group_shift);
		if (!b[7])
			return 1'b1;
		group_shift = (group_shift + 7 > 35) ? 35 : group_shift + 7;
		return 1'b0;
	endfunction

	function automatic logic [31:0] unzigzag(input logic [31:0] v);
		return (v >> 1) ^ {32{v[0]}};
	endfunction

	// next field the held op still needs after 'from', or the next op
	function automatic parse_phase_t following_phase(input logic [7:0] op,
			input parse_phase_t from);
		if (from < PARSE_FILE && op[sdsd_pkg::OP_FILE_BIT]) return PARSE_FILE;
		if (from < PARSE_FUNC && op[sdsd_pkg::OP_FUNC_BIT]) return PARSE_FUNC;
		if (from < PARSE_LINE && op[sdsd_pkg::OP_LINE_BIT]) return PARSE_LINE;
		if (from < PARSE_STEP && op[2:0] == sdsd_pkg::STEP_EXTRA) return PARSE_STEP;
		return PARSE_OP;
	endfunction

	function automatic void keep_field(input parse_phase_t at, input logic [31:0] v);
		case (at)
			PARSE_FILE: file_delta = unzigzag(v);
			PARSE_FUNC: func_delta = unzigzag(v);
			PARSE_LINE: line_delta = unzigzag(v);
			PARSE_STEP: extra_words = v;
			default: ;
		endcase
	endfunction

	// apply the held op to its context and advance the address
	function automatic symbol_record_t close_record(input logic cut);
		symbol_record_t rec;
		int             sel;
		logic [31:0]    step;
		logic [31:0]    sym;
		sel = held_op[sdsd_pkg::OP_INLINE_BIT] ? 1 : 0;
		ctx_file[sel] += file_delta;
		ctx_func[sel] += func_delta;
		ctx_line[sel] += line_delta;
		if (held_op[2:0] == sdsd_pkg::STEP_EXTRA)
			step = (extra_words + 32'd7) << 2;
		else
			step = 32'(held_op[2:0]) << 2;
		sym = addr_now + step;
		if (held_op[sdsd_pkg::OP_FSTART_BIT])
			fn_addr = sym;
		rec.rec_addr   = sym;
		rec.file_num   = ctx_file[sel];
		rec.func_num   = ctx_func[sel];
		rec.line_num   = ctx_line[sel];
		rec.fn_offset  = (fn_addr != 0) ? sym - fn_addr : 32'h0;
		rec.fn_start   = held_op[sdsd_pkg::OP_FSTART_BIT];
		rec.inline_rec = held_op[sdsd_pkg::OP_INLINE_BIT];
		rec.rec_index  = records_out;
		rec.cut        = cut;
		records_out++;
		addr_now = sym;
		return rec;
	endfunction

	// advance the shadow decoder by one accepted word
	function automatic bit decode_byte(input logic [7:0] b, input logic first,
			input logic last, input logic [31:0] start, output symbol_record_t rec);
		bit produced;
		produced = 1'b0;
		rec = '0;
		if (first) begin
			ctx_file = '{default: '0};
			ctx_func = '{default: '0};
			ctx_line = '{default: '0};
			file_delta = '0;
			func_delta = '0;
			line_delta = '0;
			extra_words = '0;
			addr_now = start;
			fn_addr = '0;
			held_op = '0;
			parse_at = PARSE_HEADER;
			group_acc = '0;
			group_shift = 0;
		end
		case (parse_at)
			PARSE_HEADER: begin
				if (take_group(b)) begin
					fn_addr = (group_acc != 0) ? addr_now - group_acc : 32'h0;
					group_acc = '0;
					group_shift = 0;
					parse_at = PARSE_OP;
				end
			end
			PARSE_OP: begin
				held_op = b;
				file_delta = '0;
				func_delta = '0;
				line_delta = '0;
				extra_words = '0;
				group_acc = '0;
				group_shift = 0;
				parse_at = following_phase(b, PARSE_OP);
				if (parse_at == PARSE_OP) begin
					rec = close_record(1'b0);
					produced = 1'b1;
				end
			end
			PARSE_FILE, PARSE_FUNC, PARSE_LINE, PARSE_STEP: begin
				if (take_group(b)) begin
					keep_field(parse_at, group_acc);
					group_acc = '0;
					group_shift = 0;
					parse_at = following_phase(held_op, parse_at);
					if (parse_at == PARSE_OP) begin
						rec = close_record(1'b0);
						produced = 1'b1;
					end
				end
			end
			default: parse_at = PARSE_DONE;
		endcase
		// chunk end closes an open record with what has arrived
		if (last) begin
			if (parse_at >= PARSE_FILE && parse_at <= PARSE_STEP) begin
				keep_field(parse_at, group_acc);
				rec = close_record(1'b1);
				produced = 1'b1;
			end
			parse_at = PARSE_DONE;
			group_acc = '0;
			group_shift = 0;
		end
		return produced;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endfunction

	// compare records leaving the block, then predict from the word entering it
	always @(posedge clk) begin
		symbol_record_t want;
		symbol_record_t pred;
		if (arst_n && record_valid && !record_stall) begin
			if (expected_records.size() == 0) begin
				$error("record word with nothing expected, symbol_addr %0h", symbol_addr);
				error_count++;
			end else begin
				want = expected_records.pop_front();
				check_field("symbol_addr", want.rec_addr, symbol_addr);
				check_field("file_number", want.file_num, file_number);
				check_field("function_number", want.func_num, function_number);
				check_field("line_number", want.line_num, line_number);
				check_field("function_offset", want.fn_offset, function_offset);
				check_field("is_function_start", 32'(want.fn_start), 32'(is_function_start));
				check_field("is_inline_record", 32'(want.inline_rec), 32'(is_inline_record));
				check_field("record_count", want.rec_index, record_count);
				check_field("cut_short", 32'(want.cut), 32'(cut_short));
			end
		end
		if (arst_n && byte_valid && !byte_stall) begin
			if (decode_byte(stream_byte, first_of_chunk, last_of_chunk, chunk_start_addr, pred))
				expected_records.push_back(word_has_typed ? word_typed : pred);
			else if (word_has_typed)
				expected_records.push_back(word_typed);
		end
	end

	// receiver: random stall, or a long hold-off when requested
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			record_stall <= 1'b1;
		end else begin
			record_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic logic [31:0] wide_value();
		return $urandom() >> $urandom_range(0, 31);
	endfunction

	// append an unsigned varint, sometimes stretched with extra groups
	function automatic void add_varint(input logic [31:0] v);
		int         pad;
		logic [7:0] grp;
		pad = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0;
		do begin
			grp = {1'b0, v[6:0]};
			v = v >> 7;
			if (v != 0 || pad != 0)
				grp[7] = 1'b1;
			chunk_bytes.push_back(grp);
		end while (v != 0);
		for (int i = 0; i < pad; i++)
			chunk_bytes.push_back({i != pad - 1, 7'($urandom())});
	endfunction

	function automatic void push_word(input logic [7:0] b, input logic first,
			input logic last, input logic [31:0] start);
		stream_word_t w;
		w = '0;
		w.b = b;
		w.first = first;
		w.last = last;
		w.start = start;
		word_plan.push_back(w);
	endfunction

	// well-formed chunk with random content, sometimes cut, unended or trailed by junk
	function automatic int plan_chunk();
		logic [31:0] base;
		logic [7:0]  op;
		int          mode;
		int          keep;
		int          junk;
		chunk_bytes = {};
		case ($urandom_range(3))
			0: base = '0;
			1: base = '1;
			default: base = $urandom();
		endcase
		add_varint(($urandom_range(3) == 0) ? 32'h0 : wide_value());
		repeat ($urandom_range(1, 10)) begin
			op = 8'($urandom());
			chunk_bytes.push_back(op);
			if (op[sdsd_pkg::OP_FILE_BIT]) add_varint(wide_value());
			if (op[sdsd_pkg::OP_FUNC_BIT]) add_varint(wide_value());
			if (op[sdsd_pkg::OP_LINE_BIT]) add_varint(wide_value());
			if (op[2:0] == sdsd_pkg::STEP_EXTRA)
				add_varint(($urandom_range(7) == 0) ? $urandom() : $urandom_range(0, 40));
		end
		mode = $urandom_range(99);
		if (mode < 15) begin
			keep = $urandom_range(1, chunk_bytes.size());
			while (chunk_bytes.size() > keep)
				void'(chunk_bytes.pop_back());
		end
		foreach (chunk_bytes[i])
			push_word(chunk_bytes[i], i == 0, i == chunk_bytes.size() - 1 && mode < 90,
				(i == 0) ? base : $urandom());
		junk = 0;
		if (mode >= 80 && mode < 90) begin
			junk = $urandom_range(1, 4);
			repeat (junk)
				push_word(8'($urandom()), 1'b0, 1'($urandom()), $urandom());
		end
		return chunk_bytes.size() + junk;
	endfunction

	// short run of arbitrary words
	function automatic int plan_noise();
		int n;
		n = $urandom_range(1, 6);
		repeat (n)
			push_word(8'($urandom()), $urandom_range(7) == 0, 1'($urandom()), $urandom());
		return n;
	endfunction

	// offer one word; entered and left at a falling edge
	task automatic send_word(input stream_word_t w);
		if ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(negedge clk);
		end
		byte_valid       <= 1'b1;
		stream_byte      <= w.b;
		first_of_chunk   <= w.first;
		last_of_chunk    <= w.last;
		chunk_start_addr <= w.start;
		word_has_typed   <= w.has_typed;
		word_typed       <= w.typed;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drive_plan();
		while (word_plan.size() != 0)
			send_word(word_plan.pop_front());
	endtask

	// main sequence
	initial begin
		int planned;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			word_plan.push_back(directed_rows[i]);
		drive_plan();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
				3: begin send_idle_pct = 20; recv_stall_pct = 20; end
				4: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_request = 1'b1; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			planned = 0;
			while (planned < PHASE_WORDS)
				planned += ($urandom_range(9) == 0) ? plan_noise() : plan_chunk();
			drive_plan();
		end
		byte_valid <= 1'b0;

		while (expected_records.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
